[design/ranked_table_upsert_assert.svh]
// assertion macros shared by the checker
`ifndef RANKED_TABLE_UPSERT_ASSERT_SVH
`define RANKED_TABLE_UPSERT_ASSERT_SVH

// same-cycle implication
`define RTU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtu check failed");

// next-cycle implication
`define RTU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtu check failed");

`endif

[design/rtu_pkg.sv]
// ----------------------------------------------------------------------------
// rtu_pkg
// types and constants for the ranked table
// ----------------------------------------------------------------------------
package rtu_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int AW          = $clog2(TABLE_DEPTH);
   localparam int CW          = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 64;
   localparam int TIME_W      = 32;
   localparam int RANK_W      = 7;
   localparam int COUNT_W     = 8;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] total;
      logic [TIME_W-1:0] run;
   } entry_type;

   typedef enum logic [1:0] {
      RD_J,
      RD_JM1,
      RD_JP1,
      RD_RANK
   } rd_sel_type;

   // commands from controller to datapath
   typedef struct packed {
      rd_sel_type rd_sel;
      logic       latch;
      logic       inc_j;
      logic       load_hit;
      logic       load_new;
      logic       wr_up;
      logic       wr_dn;
      logic       place;
      logic       res_read;
      logic       res_drop;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic op_read;
      logic key_eq;
      logic m_before_d;
      logic d_before_m;
      logic j_zero;
      logic j_at_pos;
      logic j_next_lt_n;
      logic j_eq_n;
      logic full;
   } status_type;

   // strict ranking order: total first, then last-run value
   function automatic logic ranks_before(entry_type a, entry_type b);
      if (a.total != b.total) begin
         return a.total > b.total;
      end
      return a.run > b.run;
   endfunction

endpackage

[design/rtu_dpath.sv]
// ----------------------------------------------------------------------------
// rtu_dpath
// table memory, moving entry register, index counters and result registers
// ----------------------------------------------------------------------------
module rtu_dpath import rtu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                req_operation,
   input  logic [KEY_W-1:0]    req_user_key,
   input  logic [TIME_W-1:0]   req_add_time,
   input  logic [TIME_W-1:0]   req_run_time,
   input  logic [RANK_W-1:0]   req_read_rank,
   output logic [RANK_W-1:0]   rsp_rank,
   output logic [KEY_W-1:0]    rsp_entry_key,
   output logic [TIME_W-1:0]   rsp_total_time,
   output logic [TIME_W-1:0]   rsp_last_run_time,
   output logic                rsp_entry_valid,
   output logic                rsp_dropped_full,
   output logic [COUNT_W-1:0]  rsp_entry_count
);

   entry_type mem [TABLE_DEPTH];
   entry_type rdata_ff;

   logic                op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [TIME_W-1:0]   add_ff;
   logic [TIME_W-1:0]   run_ff;
   logic [RANK_W-1:0]   rr_ff;
   logic [CW-1:0]       j_ff, j_in;
   logic [CW-1:0]       pos_ff;
   logic [CW-1:0]       count_ff, count_in;
   entry_type           m_ff;

   logic [RANK_W-1:0]   rank_ff;
   entry_type           res_ff;
   logic                valid_ff;
   logic                drop_ff;
   logic [COUNT_W-1:0]  res_count_ff;

   logic [CW-1:0]       rd_idx;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   entry_type           wr_data;
   logic [TIME_W:0]     sum;
   logic [TIME_W-1:0]   sat_total;
   logic [CW+RANK_W-1:0] rr_wide, n_wide;
   logic                rank_lt_n;
   logic [CW+RANK_W-1:0] j_wide;
   logic [CW+COUNT_W-1:0] count_wide;
   logic [CW+RANK_W-1:0] rr_addr_wide;

   // read address select
   assign rr_addr_wide = {{CW{1'b0}}, rr_ff};
   always_comb begin
      unique case (cmd.rd_sel)
         RD_J:    rd_idx = j_ff;
         RD_JM1:  rd_idx = j_ff - CW'(1);
         RD_JP1:  rd_idx = j_ff + CW'(1);
         RD_RANK: rd_idx = rr_addr_wide[CW-1:0];
         default: rd_idx = j_ff;
      endcase
   end
   assign rd_addr = rd_idx[AW-1:0];

   // table memory, one write and one registered read per cycle
   assign wr_en   = cmd.wr_up | cmd.wr_dn | cmd.place;
   assign wr_data = cmd.place ? m_ff : rdata_ff;
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[j_ff[AW-1:0]] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // saturating add on a hit
   assign sum       = {1'b0, rdata_ff.total} + {1'b0, add_ff};
   assign sat_total = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

   // index and count next values
   always_comb begin
      j_in     = j_ff;
      count_in = count_ff;
      priority if (cmd.latch) begin
         j_in = '0;
      end else if (cmd.inc_j || cmd.wr_dn) begin
         j_in = j_ff + CW'(1);
      end else if (cmd.wr_up) begin
         j_in = j_ff - CW'(1);
      end else if (cmd.load_new) begin
         j_in     = count_ff;
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // request and moving entry registers
   always_ff @(posedge clock) begin
      j_ff <= j_in;
      if (cmd.latch) begin
         op_ff  <= req_operation;
         key_ff <= req_user_key;
         add_ff <= req_add_time;
         run_ff <= req_run_time;
         rr_ff  <= req_read_rank;
      end
      if (cmd.load_hit) begin
         m_ff   <= '{key: rdata_ff.key, total: sat_total, run: run_ff};
         pos_ff <= j_ff;
      end else if (cmd.load_new) begin
         m_ff   <= '{key: key_ff, total: add_ff, run: run_ff};
         pos_ff <= count_ff;
      end
   end

   // result registers
   assign rr_wide    = {{CW{1'b0}}, rr_ff};
   assign n_wide     = {{RANK_W{1'b0}}, count_ff};
   assign rank_lt_n  = rr_wide < n_wide;
   assign j_wide     = {{RANK_W{1'b0}}, j_ff};
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.place) begin
         rank_ff  <= j_wide[RANK_W-1:0];
         res_ff   <= m_ff;
         valid_ff <= 1'b1;
         drop_ff  <= 1'b0;
      end else if (cmd.res_read) begin
         rank_ff  <= rr_ff;
         res_ff   <= rank_lt_n ? rdata_ff : '0;
         valid_ff <= rank_lt_n;
         drop_ff  <= 1'b0;
      end else if (cmd.res_drop) begin
         rank_ff  <= '0;
         res_ff   <= '0;
         valid_ff <= 1'b0;
         drop_ff  <= 1'b1;
      end
      if (cmd.place || cmd.res_read || cmd.res_drop) begin
         res_count_ff <= count_wide[COUNT_W-1:0];
      end
   end

   assign rsp_rank          = rank_ff;
   assign rsp_entry_key     = res_ff.key;
   assign rsp_total_time    = res_ff.total;
   assign rsp_last_run_time = res_ff.run;
   assign rsp_entry_valid   = valid_ff;
   assign rsp_dropped_full  = drop_ff;
   assign rsp_entry_count   = res_count_ff;

   // status toward the controller
   assign status.op_read     = op_ff;
   assign status.key_eq      = rdata_ff.key == key_ff;
   assign status.m_before_d  = ranks_before(m_ff, rdata_ff);
   assign status.d_before_m  = ranks_before(rdata_ff, m_ff);
   assign status.j_zero      = j_ff == '0;
   assign status.j_at_pos    = j_ff == pos_ff;
   assign status.j_next_lt_n = (j_ff + CW'(1)) < count_ff;
   assign status.j_eq_n      = j_ff == count_ff;
   assign status.full        = count_ff == CW'(TABLE_DEPTH);

endmodule

[design/rtu_ctrl.sv]
// ----------------------------------------------------------------------------
// rtu_ctrl
// sequencer for key scan, bubble re-rank, rank read and handshakes
// ----------------------------------------------------------------------------
module rtu_ctrl import rtu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISP, S_SRD, S_SCMP, S_UPRD, S_UPCMP,
      S_DNRD, S_DNCMP, S_PLACE, S_RRD, S_RRES, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_J;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.latch = 1'b1;
               state_in  = S_DISP;
            end
         end
         S_DISP: state_in = status.op_read ? S_RRD : S_SRD;
         S_RRD: begin
            cmd.rd_sel = RD_RANK;
            state_in   = S_RRES;
         end
         S_RRES: begin
            cmd.res_read = 1'b1;
            state_in     = S_OUT;
         end
         S_SRD: begin
            priority if (status.j_eq_n && status.full) begin
               cmd.res_drop = 1'b1;
               state_in     = S_OUT;
            end else if (status.j_eq_n) begin
               cmd.load_new = 1'b1;
               state_in     = S_UPRD;
            end else begin
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            if (status.key_eq) begin
               cmd.load_hit = 1'b1;
               state_in     = S_UPRD;
            end else begin
               cmd.inc_j = 1'b1;
               state_in  = S_SRD;
            end
         end
         // move toward the head while the entry ranks before its neighbor
         S_UPRD: begin
            cmd.rd_sel = RD_JM1;
            priority if (status.j_zero) begin
               state_in = status.j_at_pos ? S_DNRD : S_PLACE;
            end else begin
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            priority if (status.m_before_d) begin
               cmd.wr_up = 1'b1;
               state_in  = S_UPRD;
            end else begin
               state_in = status.j_at_pos ? S_DNRD : S_PLACE;
            end
         end
         // move toward the tail while the neighbor ranks before the entry
         S_DNRD: begin
            cmd.rd_sel = RD_JP1;
            state_in   = status.j_next_lt_n ? S_DNCMP : S_PLACE;
         end
         S_DNCMP: begin
            if (status.d_before_m) begin
               cmd.wr_dn = 1'b1;
               state_in  = S_DNRD;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= state_in == S_IDLE;
         rsp_valid_ff <= state_in == S_OUT;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/ranked_table_upsert.sv]
// ----------------------------------------------------------------------------
// ranked_table_upsert
// sorted table of keyed entries with upsert and read by rank
// ----------------------------------------------------------------------------
// read: accept, dispatch, table read at the requested rank, result capture
// upsert: a table read and a compare for each entry scanned for the key, then a
//   table read and a compare for each position the entry moves, then placement
// one transaction in flight at a time; next accept follows result handoff
// reset empties the table at once (entry count cleared), no clearing pass
module ranked_table_upsert import rtu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [KEY_W-1:0]    req_user_key,
   input  logic [TIME_W-1:0]   req_add_time,
   input  logic [TIME_W-1:0]   req_run_time,
   input  logic [RANK_W-1:0]   req_read_rank,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [RANK_W-1:0]   rsp_rank,
   output logic [KEY_W-1:0]    rsp_entry_key,
   output logic [TIME_W-1:0]   rsp_total_time,
   output logic [TIME_W-1:0]   rsp_last_run_time,
   output logic                rsp_entry_valid,
   output logic                rsp_dropped_full,
   output logic [COUNT_W-1:0]  rsp_entry_count
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   rtu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table and result datapath
   rtu_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_user_key      (req_user_key),
      .req_add_time      (req_add_time),
      .req_run_time      (req_run_time),
      .req_read_rank     (req_read_rank),
      .rsp_rank          (rsp_rank),
      .rsp_entry_key     (rsp_entry_key),
      .rsp_total_time    (rsp_total_time),
      .rsp_last_run_time (rsp_last_run_time),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_dropped_full  (rsp_dropped_full),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule

[design/rtu_checker.sv]
// ----------------------------------------------------------------------------
// rtu_checker
// port-level checks on the ranked table, bound to the top level
// ----------------------------------------------------------------------------
`include "ranked_table_upsert_assert.svh"

module rtu_checker import rtu_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_entry_valid,
   input logic               rsp_dropped_full,
   input logic [COUNT_W-1:0] rsp_entry_count
);

   // a pending result stays up
   `RTU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // no new transaction while a result is pending
   `RTU_ASSERT_NOW(a_one_in_flight, clock, reset, rsp_valid, !req_ready)
   // a drop never reports an entry
   `RTU_ASSERT_NOW(a_drop_no_entry, clock, reset, rsp_valid && rsp_dropped_full,
      !rsp_entry_valid)
   // a reported entry implies a non-empty table
   `RTU_ASSERT_NOW(a_valid_count, clock, reset, rsp_valid && rsp_entry_valid,
      rsp_entry_count != '0)

endmodule

bind ranked_table_upsert rtu_checker u_rtu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_entry_valid  (rsp_entry_valid),
   .rsp_dropped_full (rsp_dropped_full),
   .rsp_entry_count  (rsp_entry_count)
);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the ranked table against a predictor of its sorted contents, using
// directed and random upserts and reads under random idling on both channels
// ----------------------------------------------------------------------------
module testbench;
   import rtu_pkg::*;

   typedef struct packed {
      logic [RANK_W-1:0]  rank;
      logic [KEY_W-1:0]   key;
      logic [TIME_W-1:0]  total;
      logic [TIME_W-1:0]  run;
      logic               valid;
      logic               drop;
      logic [COUNT_W-1:0] count;
   } table_rsp_type;

   class rank_scoreboard;
      logic [KEY_W-1:0]  keys[TABLE_DEPTH];
      logic [TIME_W-1:0] totals[TABLE_DEPTH];
      logic [TIME_W-1:0] runs[TABLE_DEPTH];
      int                held;
      table_rsp_type     pending_rsp[$];
      int                mismatches;

      function void clear();
         held = 0;
         mismatches = 0;
         pending_rsp.delete();
      endfunction

      function bit goes_first(logic [TIME_W-1:0] ta, logic [TIME_W-1:0] ra,
                              logic [TIME_W-1:0] tb, logic [TIME_W-1:0] rb);
         if (ta != tb) return ta > tb;
         return ra > rb;
      endfunction

      // move entry at pos to its ranked place
      function int settle(int pos);
         logic [KEY_W-1:0]  k;
         logic [TIME_W-1:0] t;
         logic [TIME_W-1:0] r;
         int dest;
         k = keys[pos]; t = totals[pos]; r = runs[pos];
         dest = 0;
         for (int j = 0; j < held; j++) begin
            if (j == pos) continue;
            if (goes_first(totals[j], runs[j], t, r) ||
                (j < pos && totals[j] == t && runs[j] == r)) dest++;
         end
         if (dest < pos) begin
            for (int j = pos; j > dest; j--) begin
               keys[j] = keys[j-1]; totals[j] = totals[j-1]; runs[j] = runs[j-1];
            end
         end else begin
            for (int j = pos; j < dest; j++) begin
               keys[j] = keys[j+1]; totals[j] = totals[j+1]; runs[j] = runs[j+1];
            end
         end
         keys[dest] = k; totals[dest] = t; runs[dest] = r;
         return dest;
      endfunction

      function void note_request(logic op, logic [KEY_W-1:0] key,
                                 logic [TIME_W-1:0] add, logic [TIME_W-1:0] run,
                                 logic [RANK_W-1:0] rr);
         table_rsp_type e;
         int pos;
         bit hit;
         logic [TIME_W:0] sum;
         e = '0;
         if (op) begin
            e.rank = rr;
            if (rr < held) begin
               e.key = keys[rr]; e.total = totals[rr]; e.run = runs[rr]; e.valid = 1;
            end
         end else begin
            pos = held;
            hit = 0;
            for (int i = 0; i < held; i++) begin
               if (keys[i] == key) begin pos = i; hit = 1; break; end
            end
            if (hit) begin
               sum = totals[pos] + add;
               totals[pos] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
               runs[pos] = run;
            end else if (held < TABLE_DEPTH) begin
               keys[pos] = key; totals[pos] = add; runs[pos] = run;
               held++;
               hit = 1;
            end else begin
               e.drop = 1;
            end
            if (hit) begin
               pos = settle(pos);
               e.rank = pos[RANK_W-1:0]; e.key = keys[pos]; e.total = totals[pos];
               e.run = runs[pos]; e.valid = 1;
            end
         end
         e.count = COUNT_W'(held);
         pending_rsp.push_back(e);
      endfunction

      function void check_response(table_rsp_type got);
         table_rsp_type want;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         want = pending_rsp.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_operation;
   logic [KEY_W-1:0]   req_user_key;
   logic [TIME_W-1:0]  req_add_time;
   logic [TIME_W-1:0]  req_run_time;
   logic [RANK_W-1:0]  req_read_rank;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [RANK_W-1:0]  rsp_rank;
   logic [KEY_W-1:0]   rsp_entry_key;
   logic [TIME_W-1:0]  rsp_total_time;
   logic [TIME_W-1:0]  rsp_last_run_time;
   logic               rsp_entry_valid;
   logic               rsp_dropped_full;
   logic [COUNT_W-1:0] rsp_entry_count;

   rank_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   logic [KEY_W-1:0] key_pool[16];

   localparam logic OP_UPSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   ranked_table_upsert u_top (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400000000;
      $display("TEST FAILED");
      $finish;
   end

   // receiver with random stalls; checks each response transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_rank, rsp_entry_key, rsp_total_time,
                               rsp_last_run_time, rsp_entry_valid,
                               rsp_dropped_full, rsp_entry_count});
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // valid stays up after an accept until the next idle cycle or drain
   task send(logic op, logic [KEY_W-1:0] key, logic [TIME_W-1:0] add,
             logic [TIME_W-1:0] run, logic [RANK_W-1:0] rr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_user_key <= key;
      req_add_time <= add;
      req_run_time <= run;
      req_read_rank <= rr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, key, add, run, rr);
   endtask

   task drain();
      req_valid <= 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   // mostly reuse a small pool of keys so hits are common
   task random_item(int fill_bias);
      logic [KEY_W-1:0] k;
      int sel;
      sel = $urandom_range(99);
      k = (sel < fill_bias) ? {$urandom, $urandom} : key_pool[$urandom_range(15)];
      if ($urandom_range(3) == 0)
         send(OP_READ, {$urandom, $urandom}, $urandom, $urandom,
              (sb.held > 0 && $urandom_range(3) != 0) ?
                 RANK_W'($urandom_range(sb.held - 1)) : RANK_W'($urandom_range(127)));
      else
         send(OP_UPSERT, k,
              ($urandom_range(3) == 0) ? $urandom_range(15) :
              ($urandom_range(7) == 0) ? 32'hFFFF_FFF0 | $urandom_range(15) :
              $urandom, ($urandom_range(2) == 0) ? $urandom_range(3) : $urandom,
              RANK_W'($urandom_range(127)));
   endtask

   initial begin
      sb = new();
      sb.clear();
      reset = 1;
      req_valid = 0;
      req_operation = 0;
      req_user_key = 0;
      req_add_time = 0;
      req_run_time = 0;
      req_read_rank = 0;
      send_idle_pct = 11;
      recv_idle_pct = 61;
      for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty read, extremes, saturation, ties
      send(OP_READ, '0, '0, '0, 7'd0);
      send(OP_READ, '1, '1, '1, 7'd127);
      send(OP_UPSERT, '0, '0, '0, '0);
      send(OP_UPSERT, '1, '1, '1, '1);
      send(OP_UPSERT, '1, 32'd5, 32'd0, '0);
      send(OP_UPSERT, 64'd7, 32'd100, 32'd9, '0);
      send(OP_UPSERT, 64'd8, 32'd100, 32'd9, '0);
      send(OP_UPSERT, 64'd9, 32'd100, 32'd10, '0);
      send(OP_UPSERT, 64'd7, 32'd0, 32'd9, '0);
      send(OP_UPSERT, '0, 32'd200, 32'h8000_0000, '0);
      for (int r = 0; r < 7; r++) send(OP_READ, '0, '0, '0, r[RANK_W-1:0]);
      drain();

      // fill the table (pool keys first), then hit table-full drops
      for (int i = 0; i < 140; i++)
         send(OP_UPSERT, (i < 16) ? key_pool[i] : {$urandom, $urandom},
              $urandom_range(1000), $urandom_range(3), '0);
      send(OP_READ, '0, '0, '0, 7'd127);
      send(OP_UPSERT, key_pool[0], $urandom, $urandom, '0);
      drain();
      sb.held = sb.held; // table stays full here; random part probes hits

      for (int i = 0; i < 450; i++) random_item(3);
      drain();
      send_idle_pct = 61;
      recv_idle_pct = 11;
      for (int i = 0; i < 400; i++) random_item(3);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 350; i++) random_item(3);
      drain();
      repeat (2000) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
